// ===== rtl/mh2_pkg.sv =====
// Shared types, constants and mixing functions for the MurmurHash2 stream block.
package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'ha5a8ae1e;

    // One classified request as it travels from the front end to the hash core.
    typedef struct packed {
        logic        start;  // first request of a message, hash starts from init
        logic        last;   // final request, the finished hash is delivered
        logic        skip;   // short word with no valid bytes leaves the hash as is
        logic        full;   // full word, post holds the premixed word
        logic [31:0] init;   // seed XOR message length
        logic [31:0] pre;    // masked tail bytes, zero for a full word
        logic [31:0] post;   // premixed word k
    } t_op;

    function automatic logic [31:0] mul32(input logic [31:0] a);
        return a * MIX_MUL;
    endfunction

    function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
        logic [31:0] m;
        case (cnt)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/murmurhash2_stream_top.sv =====
// Streaming MurmurHash2: one request per cycle in unless full, one hash per message out.
// Throughput: one request per cycle unless full; one multiply per word in the core sets this.
// After its last request is accepted, the hash of a message passes two premix stages,
// the request queue, the recurrence, the avalanche stage and the result queue.
// Reset: synchronous, active low; queues empty, no message open, seed back to 0xa5a8ae1e.
module murmurhash2_stream_top #(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic [30:0] i_message_length,
    input  logic        i_last_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value
);

    import mh2_pkg::*;

    localparam int OP_W = $bits(t_op);

    logic        f_valid;
    t_op         f_op;
    logic        q_empty;
    t_op         q_op;
    logic        b_pop;
    logic        r_valid;
    logic [31:0] r_hash_w;
    logic        out_release;

    assign out_release = pop && !empty;

    mh2_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_message_length (i_message_length),
        .i_last_item      (i_last_item),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_release        (b_pop),
        .o_op_valid       (f_valid),
        .o_op             (f_op)
    );

    mh2_fifo #(.WIDTH(OP_W), .DEPTH(QUEUE_DEPTH)) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_op),
        .i_pop   (b_pop),
        .o_empty (q_empty),
        .o_data  (q_op)
    );

    mh2_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (!q_empty),
        .i_op          (q_op),
        .o_op_pop      (b_pop),
        .o_res_valid   (r_valid),
        .o_res_hash    (r_hash_w),
        .i_res_release (out_release)
    );

    mh2_fifo #(.WIDTH(32), .DEPTH(OUT_DEPTH)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_valid),
        .i_data  (r_hash_w),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_hash_value)
    );

endmodule

// ===== rtl/mh2_fifo.sv =====
// Small synchronous queue built from registers.
module mh2_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        n_count = r_count + CW'(i_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    // The senders hold credits, so a push never lands on a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FULL_CNT))
        else $error("mh2_fifo: push into a full queue");
`endif

endmodule

// ===== rtl/mh2_front.sv =====
// Front end: takes requests, classifies them and premixes the data word.
module mh2_front #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [31:0]   i_data_word,
    input  logic [2:0]    i_byte_count,
    input  logic [30:0]   i_message_length,
    input  logic          i_last_item,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_release,
    output logic          o_op_valid,
    output mh2_pkg::t_op  o_op
);

    import mh2_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CRED_MAX = CW'(DEPTH);

    logic [31:0]   r_seed;
    logic [CW-1:0] r_cred, n_cred;
    logic          r_in_msg;
    logic          r_s1_v, r_s2_v;
    t_op           r_s1, n_s1;
    t_op           r_s2, n_s2;
    logic          accept;

    assign full       = (r_cred == '0);
    assign accept     = push && !full;
    assign o_op_valid = r_s2_v;
    assign o_op       = r_s2;

    always_comb begin
        n_s1.start = !r_in_msg;
        n_s1.last  = i_last_item;
        n_s1.full  = i_byte_count[2];
        n_s1.skip  = !i_byte_count[2] && (i_byte_count[1:0] == 2'd0);
        n_s1.init  = r_seed ^ {1'b0, i_message_length};
        n_s1.pre   = i_byte_count[2] ? 32'h0 : (i_data_word & tail_mask(i_byte_count[1:0]));
        // First half of the word mix; post carries k until the second multiply.
        n_s1.post  = mul32(i_data_word);

        n_s2      = r_s1;
        n_s2.post = mul32(r_s1.post ^ (r_s1.post >> MIX_SHIFT));

        n_cred = r_cred - CW'(accept) + CW'(i_release);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= SEED_RESET;
            r_cred   <= CRED_MAX;
            r_in_msg <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (accept) begin
                r_in_msg <= !i_last_item;
            end
            r_cred <= n_cred;
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
    end

`ifndef ASSERT_OFF
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= CRED_MAX)
        else $error("mh2_front: queue credits above queue depth");

    // Every accepted request passes the r_s1 and r_s2 stages into the queue.
    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 r_s2_v)
        else $error("mh2_front: accepted request lost in premix stages");
`endif

endmodule

// ===== rtl/mh2_back.sv =====
// Hash core: runs the per-word recurrence and the final avalanche.
module mh2_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  mh2_pkg::t_op  i_op,
    output logic          o_op_pop,
    output logic          o_res_valid,
    output logic [31:0]   o_res_hash,
    input  logic          i_res_release
);

    import mh2_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam logic [CW-1:0] CRED_MAX = CW'(OUT_DEPTH);

    logic [CW-1:0] r_cred, n_cred;
    logic [31:0]   r_hash;
    logic [31:0]   r_fin;
    logic          r_done;
    logic          r_fin_v;
    logic [31:0]   h_base;
    logic [31:0]   h_mul;
    logic [31:0]   h_new;
    logic          take_last;

    // A final request waits until the result queue has room for its hash.
    assign o_op_pop  = i_op_valid && (!i_op.last || (r_cred != '0));
    assign take_last = o_op_pop && i_op.last;

    always_comb begin
        h_base = i_op.start ? i_op.init : r_hash;
        h_mul  = mul32(h_base ^ i_op.pre);
        if (i_op.skip) begin
            h_new = h_base;
        end else if (i_op.full) begin
            h_new = h_mul ^ i_op.post;
        end else begin
            h_new = h_mul;
        end
        n_cred = r_cred - CW'(take_last) + CW'(i_res_release);
    end

    assign o_res_valid = r_fin_v;
    assign o_res_hash  = r_fin ^ (r_fin >> FIN_SHIFT_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred  <= CRED_MAX;
            r_done  <= 1'b0;
            r_fin_v <= 1'b0;
        end else begin
            r_cred  <= n_cred;
            r_done  <= take_last;
            r_fin_v <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_hash <= h_new;
        end
        if (r_done) begin
            r_fin <= mul32(r_hash ^ (r_hash >> FIN_SHIFT_A));
        end
    end

`ifndef ASSERT_OFF
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= CRED_MAX)
        else $error("mh2_back: result credits above queue depth");

    a_fin_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> ##1 o_res_valid)
        else $error("mh2_back: finished hash not delivered");
`endif

endmodule

// ===== tb/mh2_checker.sv =====
// Checker for the MurmurHash2 stream block: predicts each message hash and compares results.
`timescale 1ns / 100ps

module mh2_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic [30:0] i_message_length,
    input  logic        i_last_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_hash_value,
    output int          o_fail_count,
    output int          o_pending
);

    import mh2_pkg::*;

    logic [31:0] seed_copy;
    logic [31:0] chain_hash;
    logic        msg_open;
    logic [31:0] step_hash;
    logic [31:0] wanted_hash;
    logic [31:0] expected_hashes[$];

    function automatic logic [31:0] times_m(input logic [31:0] a);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, MIX_MUL};
        return prod[31:0];
    endfunction

    // A count of four or more mixes a whole word; one to three take the tail step; zero keeps h.
    function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] word,
                                                input logic [2:0] cnt);
        logic [31:0] k;
        logic [31:0] tail_bytes;
        if (cnt >= 3'd4) begin
            k = times_m(word);
            k = k ^ (k >> MIX_SHIFT);
            k = times_m(k);
            return times_m(h) ^ k;
        end
        if (cnt == 3'd0) begin
            return h;
        end
        tail_bytes = word & ~(32'hffff_ffff << (8 * cnt));
        return times_m(h ^ tail_bytes);
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] v;
        v = h ^ (h >> FIN_SHIFT_A);
        v = times_m(v);
        return v ^ (v >> FIN_SHIFT_B);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] hash check: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_copy  = SEED_RESET;
            chain_hash = 32'd0;
            msg_open   = 1'b0;
            expected_hashes.delete();
        end else begin
            if (i_cfg_we) begin
                seed_copy = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                step_hash = msg_open ? chain_hash : (seed_copy ^ {1'b0, i_message_length});
                step_hash = absorb_word(step_hash, i_data_word, i_byte_count);
                if (i_last_item) begin
                    expected_hashes.push_back(avalanche(step_hash));
                    chain_hash = 32'd0;
                    msg_open   = 1'b0;
                end else begin
                    chain_hash = step_hash;
                    msg_open   = 1'b1;
                end
            end
            if (i_pop && !i_empty) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash_value %h", i_hash_value));
                end else begin
                    wanted_hash = expected_hashes.pop_front();
                    if (i_hash_value !== wanted_hash) begin
                        report_mismatch($sformatf("hash_value %h, expected %h",
                                                  i_hash_value, wanted_hash));
                    end
                end
            end
        end
        o_pending <= expected_hashes.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the MurmurHash2 stream testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import mh2_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 10;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        push           = 1'b0;
    logic        full;
    logic [31:0] data_word      = '0;
    logic [2:0]  byte_count     = '0;
    logic [30:0] message_length = '0;
    logic        last_item      = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [31:0] cfg_wdata      = '0;
    logic        empty;
    logic        pop            = 1'b0;
    logic [31:0] hash_value;

    int   fail_count;
    int   pending;
    int   stall_pct    = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_request = 1'b0;

    murmurhash2_stream_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_word      (data_word),
        .i_byte_count     (byte_count),
        .i_message_length (message_length),
        .i_last_item      (last_item),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .empty            (empty),
        .pop              (pop),
        .o_hash_value     (hash_value)
    );

    mh2_checker hash_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_word      (data_word),
        .i_byte_count     (byte_count),
        .i_message_length (message_length),
        .i_last_item      (last_item),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_hash_value     (hash_value),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Result side: random stalls, or a long hold-off when the stimulus asks for one.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers a request after random idle cycles; returns once an edge leaves full low.
    task automatic send_request(input logic [31:0] word, input logic [2:0] cnt,
                                input logic [30:0] len, input logic last, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        data_word      <= word;
        byte_count     <= cnt;
        message_length <= len;
        last_item      <= last;
        do begin
            @(posedge i_clk);
        end while (full);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Whole messages with random content; a few short words in the middle act as noise.
    task automatic run_messages(input int n_items, input int idle_pct, input int recv_stall);
        int          sent;
        int          n_full;
        int          k;
        logic [2:0]  tail_cnt;
        logic [2:0]  cnt;
        logic [30:0] len;
        stall_pct = recv_stall;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                n_full = $urandom_range(24, 8);
            end else begin
                n_full = $urandom_range(5);
            end
            tail_cnt = 3'($urandom_range(4));
            if ($urandom_range(15) == 0) begin
                tail_cnt = 3'($urandom_range(7, 5));
            end
            len = 31'(4 * n_full + ((tail_cnt >= 3'd4) ? 4 : tail_cnt));
            if ($urandom_range(7) == 0) begin
                len = 31'($urandom);
            end
            for (k = 0; k < n_full; k++) begin
                cnt = 3'd4;
                if ($urandom_range(7) == 0) begin
                    cnt = 3'($urandom_range(7, 5));
                end else if ($urandom_range(19) == 0) begin
                    cnt = 3'($urandom_range(3));
                end
                send_request($urandom, cnt, (k == 0) ? len : 31'($urandom), 1'b0, idle_pct);
                sent++;
            end
            send_request($urandom, tail_cnt, (n_full == 0) ? len : 31'($urandom), 1'b1,
                         idle_pct);
            sent++;
        end
    endtask

    initial begin
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset seed.
        send_request(32'h0000_0000, 3'd0, 31'd0, 1'b1, 0);
        send_request($urandom, 3'd0, 31'h7fff_ffff, 1'b1, 0);
        send_request(32'hffff_ffff, 3'd4, 31'd4, 1'b1, 0);
        send_request(32'h0000_0000, 3'd4, 31'd4, 1'b1, 0);
        // Counts above four behave as a full word.
        send_request(32'h1234_5678, 3'd5, 31'd12, 1'b0, 0);
        send_request(32'h9abc_def0, 3'd6, 31'd0, 1'b0, 0);
        send_request(32'hdead_beef, 3'd7, 31'd0, 1'b1, 0);
        // Tail bytes with the unused upper bytes set.
        send_request(32'hffff_ffff, 3'd4, 31'd5, 1'b0, 0);
        send_request(32'hffff_ffff, 3'd1, 31'd0, 1'b1, 0);
        send_request(32'hffff_ffff, 3'd2, 31'd2, 1'b1, 0);
        send_request(32'hffff_ffff, 3'd3, 31'd3, 1'b1, 0);
        // A short word opening a message, a full word, then a last word with no bytes.
        send_request(32'h0000_abcd, 3'd2, 31'd9, 1'b0, 0);
        send_request(32'h0102_0304, 3'd4, 31'h7fff_ffff, 1'b0, 0);
        send_request(32'h55aa_55aa, 3'd0, 31'd0, 1'b1, 0);
        // The length field is not checked against the bytes delivered.
        send_request(32'hcafe_f00d, 3'd3, 31'd100, 1'b1, 0);
        send_request(32'h8000_0001, 3'd3, 31'h4000_0000, 1'b1, 0);
        drain_results();

        write_seed(32'h0000_0000);
        run_messages(105, 0, 0);
        drain_results();

        write_seed(32'hffff_ffff);
        run_messages(105, 62, 0);
        drain_results();

        // Hold the result side off while single-word messages keep coming.
        write_seed($urandom);
        stall_pct = 0;
        hold_request = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_request($urandom, 3'($urandom_range(7)), 31'($urandom), 1'b1, 0);
        end
        drain_results();

        run_messages(105, 0, 62);
        drain_results();

        write_seed($urandom);
        run_messages(105, 15, 15);
        drain_results();

        write_seed(SEED_RESET);
        run_messages(20, 0, 0);
        drain_results();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
